@@ rtl/core/cubic_hermite_evaluator_top_assert.svh @@
// Assertion helpers for the Hermite evaluator; clk and rst are taken from the module scope.
`ifndef CUBIC_HERMITE_EVALUATOR_TOP_ASSERT_SVH
`define CUBIC_HERMITE_EVALUATOR_TOP_ASSERT_SVH

// Same-cycle implication.
`define CHE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cubic_hermite_evaluator_top: check failed");

// Next-cycle implication.
`define CHE_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cubic_hermite_evaluator_top: check failed");

`endif

@@ rtl/core/cheval_pkg.sv @@
package cheval_pkg;

  localparam int PHASE_BITS_DEF = 16;
  localparam int VALUE_W        = 32;
  // Horner intermediates stay within +/- 2^37
  localparam int ACC_W          = 38;

  localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ZERO_LEN  = 2'd1,
    ST_CLAMPED   = 2'd2,
    ST_SATURATED = 2'd3
  } status_t;

endpackage

@@ rtl/core/cubic_hermite_evaluator_top.sv @@
// Channel   Handshake             Payload
// request   req_valid/req_ready   time_pos, seg_length, start_value, start_tangent,
//                                 end_value, end_tangent
// result    res_valid/res_ready   curve_value, status
//
// One request per cycle sustained while results are taken.
// The pipeline is the restoring divider, one quotient bit per stage, followed by
// three multiply/add Horner steps and a saturation stage.
// Reset clears the valid bits only; payload registers are not reset.
// The whole pipeline holds while a result waits, and no request is taken then.
`include "cubic_hermite_evaluator_top_assert.svh"

module cubic_hermite_evaluator_top #(
  parameter int PHASE_BITS = cheval_pkg::PHASE_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      req_valid,
  output logic                                      req_ready,
  input  logic        [cheval_pkg::VALUE_W-1:0]     time_pos,
  input  logic        [cheval_pkg::VALUE_W-1:0]     seg_length,
  input  logic signed [cheval_pkg::VALUE_W-1:0]     start_value,
  input  logic signed [cheval_pkg::VALUE_W-1:0]     start_tangent,
  input  logic signed [cheval_pkg::VALUE_W-1:0]     end_value,
  input  logic signed [cheval_pkg::VALUE_W-1:0]     end_tangent,
  output logic                                      res_valid,
  input  logic                                      res_ready,
  output logic signed [cheval_pkg::VALUE_W-1:0]     curve_value,
  output logic        [1:0]                         status
);

  localparam int VW = cheval_pkg::VALUE_W;
  localparam int AW = cheval_pkg::ACC_W;
  localparam int PW = AW + PHASE_BITS + 2;
  localparam logic [PHASE_BITS:0] U_ONE = {1'b1, {PHASE_BITS{1'b0}}};
  localparam logic signed [AW-1:0] H_MAX = AW'(cheval_pkg::VALUE_MAX);
  localparam logic signed [AW-1:0] H_MIN = AW'(cheval_pkg::VALUE_MIN);

  logic adv;
  assign adv       = !res_valid || res_ready;
  assign req_ready = adv;

  // Polynomial coefficients, formed at entry
  logic signed [AW-1:0] p0_x, d0_x, p1_x, d1_x, diff_x, coef_a, coef_b;
  assign p0_x   = AW'(start_value);
  assign d0_x   = AW'(start_tangent);
  assign p1_x   = AW'(end_value);
  assign d1_x   = AW'(end_tangent);
  assign diff_x = p1_x - p0_x;
  assign coef_a = (p0_x <<< 1) - (p1_x <<< 1) + d0_x + d1_x;
  assign coef_b = diff_x + (diff_x <<< 1) - (d0_x <<< 1) - d1_x;

  // Divider stages: stage k resolves quotient bit PHASE_BITS-k
  logic [PHASE_BITS:0]          dv_vld;
  logic [PHASE_BITS:0]          dv_zero;
  logic [PHASE_BITS:0]          dv_clamp;
  logic [VW-1:0]                dv_rem   [PHASE_BITS+1];
  logic [VW-1:0]                dv_len   [PHASE_BITS+1];
  logic [PHASE_BITS:0]          dv_q     [PHASE_BITS+1];
  logic signed [VW-1:0]         dv_p0    [PHASE_BITS+1];
  logic signed [VW-1:0]         dv_d0    [PHASE_BITS+1];
  logic signed [AW-1:0]         dv_a     [PHASE_BITS+1];
  logic signed [AW-1:0]         dv_b     [PHASE_BITS+1];

  for (genvar k = 0; k <= PHASE_BITS; k++) begin : g_div
    logic                 vld_in, zero_in, clamp_in, ge;
    logic [VW:0]          trial, rem_next;
    logic [VW-1:0]        len_in;
    logic [PHASE_BITS:0]  q_in;
    logic signed [VW-1:0] p0_in, d0_in;
    logic signed [AW-1:0] a_in, b_in;

    if (k == 0) begin : g_first
      assign vld_in   = req_valid;
      assign zero_in  = (seg_length == '0);
      assign clamp_in = (time_pos > seg_length);
      assign trial    = {1'b0, time_pos};
      assign len_in   = seg_length;
      assign q_in     = '0;
      assign p0_in    = start_value;
      assign d0_in    = start_tangent;
      assign a_in     = coef_a;
      assign b_in     = coef_b;
    end else begin : g_rest
      assign vld_in   = dv_vld[k-1];
      assign zero_in  = dv_zero[k-1];
      assign clamp_in = dv_clamp[k-1];
      assign trial    = {dv_rem[k-1], 1'b0};
      assign len_in   = dv_len[k-1];
      assign q_in     = dv_q[k-1];
      assign p0_in    = dv_p0[k-1];
      assign d0_in    = dv_d0[k-1];
      assign a_in     = dv_a[k-1];
      assign b_in     = dv_b[k-1];
    end

    assign ge       = (trial >= {1'b0, len_in});
    assign rem_next = ge ? (trial - {1'b0, len_in}) : trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_vld[k] <= 1'b0;
      end else if (adv) begin
        dv_vld[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_zero[k]  <= zero_in;
        dv_clamp[k] <= clamp_in;
        dv_rem[k]   <= rem_next[VW-1:0];
        dv_len[k]   <= len_in;
        dv_q[k]     <= {q_in[PHASE_BITS-1:0], ge};
        dv_p0[k]    <= p0_in;
        dv_d0[k]    <= d0_in;
        dv_a[k]     <= a_in;
        dv_b[k]     <= b_in;
      end
    end
  end

  logic [PHASE_BITS:0] u_div;
  assign u_div = dv_clamp[PHASE_BITS] ? U_ONE : dv_q[PHASE_BITS];

  // Horner steps: multiply stage, then floor-shift and add stage
  logic                   m1_vld, h1_vld, m2_vld, h2_vld, m3_vld, h3_vld;
  logic signed [PW-1:0]   m1_prod, m2_prod, m3_prod;
  logic signed [PW-1:0]   m1_sh, m2_sh, m3_sh;
  logic signed [AW-1:0]   m1_b, h1_acc, h2_acc, h3_acc;
  logic signed [VW-1:0]   m1_d0, h1_d0, m2_d0;
  logic signed [VW-1:0]   m1_p0, h1_p0, m2_p0, h2_p0, m3_p0, h3_p0;
  logic [PHASE_BITS:0]    m1_u, h1_u, m2_u, h2_u;
  logic                   m1_zero, h1_zero, m2_zero, h2_zero, m3_zero, h3_zero;
  logic                   m1_clamp, h1_clamp, m2_clamp, h2_clamp, m3_clamp, h3_clamp;

  assign m1_sh = m1_prod >>> PHASE_BITS;
  assign m2_sh = m2_prod >>> PHASE_BITS;
  assign m3_sh = m3_prod >>> PHASE_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_vld <= 1'b0;
      h1_vld <= 1'b0;
      m2_vld <= 1'b0;
      h2_vld <= 1'b0;
      m3_vld <= 1'b0;
      h3_vld <= 1'b0;
    end else if (adv) begin
      m1_vld <= dv_vld[PHASE_BITS];
      h1_vld <= m1_vld;
      m2_vld <= h1_vld;
      h2_vld <= m2_vld;
      m3_vld <= h2_vld;
      h3_vld <= m3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_prod  <= PW'(dv_a[PHASE_BITS]) * PW'($signed({1'b0, u_div}));
      m1_b     <= dv_b[PHASE_BITS];
      m1_d0    <= dv_d0[PHASE_BITS];
      m1_p0    <= dv_p0[PHASE_BITS];
      m1_u     <= u_div;
      m1_zero  <= dv_zero[PHASE_BITS];
      m1_clamp <= dv_clamp[PHASE_BITS];

      h1_acc   <= m1_b + $signed(m1_sh[AW-1:0]);
      h1_d0    <= m1_d0;
      h1_p0    <= m1_p0;
      h1_u     <= m1_u;
      h1_zero  <= m1_zero;
      h1_clamp <= m1_clamp;

      m2_prod  <= PW'(h1_acc) * PW'($signed({1'b0, h1_u}));
      m2_d0    <= h1_d0;
      m2_p0    <= h1_p0;
      m2_u     <= h1_u;
      m2_zero  <= h1_zero;
      m2_clamp <= h1_clamp;

      h2_acc   <= AW'(m2_d0) + $signed(m2_sh[AW-1:0]);
      h2_p0    <= m2_p0;
      h2_u     <= m2_u;
      h2_zero  <= m2_zero;
      h2_clamp <= m2_clamp;

      m3_prod  <= PW'(h2_acc) * PW'($signed({1'b0, h2_u}));
      m3_p0    <= h2_p0;
      m3_zero  <= h2_zero;
      m3_clamp <= h2_clamp;

      h3_acc   <= AW'(m3_p0) + $signed(m3_sh[AW-1:0]);
      h3_p0    <= m3_p0;
      h3_zero  <= m3_zero;
      h3_clamp <= m3_clamp;
    end
  end

  // Output register: saturate and pick status
  cheval_pkg::status_t res_status, res_status_next;
  logic signed [VW-1:0] curve_next;

  always_comb begin
    priority if (h3_zero) begin
      curve_next      = h3_p0;
      res_status_next = cheval_pkg::ST_ZERO_LEN;
    end else if (h3_acc > H_MAX) begin
      curve_next      = cheval_pkg::VALUE_MAX;
      res_status_next = cheval_pkg::ST_SATURATED;
    end else if (h3_acc < H_MIN) begin
      curve_next      = cheval_pkg::VALUE_MIN;
      res_status_next = cheval_pkg::ST_SATURATED;
    end else begin
      curve_next      = h3_acc[VW-1:0];
      res_status_next = h3_clamp ? cheval_pkg::ST_CLAMPED : cheval_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= h3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      curve_value <= curve_next;
      res_status  <= res_status_next;
    end
  end

  assign status = res_status;

  logic [PHASE_BITS+6:0] pipe_vld;
  assign pipe_vld = {dv_vld, m1_vld, h1_vld, m2_vld, h2_vld, m3_vld, h3_vld};

  `CHE_ASSERT_IMP(a_div_rem_bound,
    dv_vld[PHASE_BITS] && !dv_zero[PHASE_BITS] && !dv_clamp[PHASE_BITS],
    dv_rem[PHASE_BITS] < dv_len[PHASE_BITS])
  `CHE_ASSERT_IMP(a_phase_bound,
    dv_vld[PHASE_BITS] && !dv_zero[PHASE_BITS],
    u_div <= U_ONE)
  `CHE_ASSERT_IMP(a_sat_value,
    res_valid && res_status == cheval_pkg::ST_SATURATED,
    curve_value == cheval_pkg::VALUE_MAX || curve_value == cheval_pkg::VALUE_MIN)
  `CHE_ASSERT_NXT(a_stall_hold, !adv, $stable(pipe_vld))

endmodule

@@ tb/sv/tb_cubic_hermite_evaluator_top.sv @@
module tb_cubic_hermite_evaluator_top;
  import cheval_pkg::*;

  localparam int PHASE_BITS     = PHASE_BITS_DEF;
  localparam int PIPE_LATENCY   = PHASE_BITS + 8;
  localparam int RANDOM_ITEMS   = 1950;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct {
    logic        [VALUE_W-1:0] time_pos;
    logic        [VALUE_W-1:0] seg_length;
    logic signed [VALUE_W-1:0] start_value;
    logic signed [VALUE_W-1:0] start_tangent;
    logic signed [VALUE_W-1:0] end_value;
    logic signed [VALUE_W-1:0] end_tangent;
  } hermite_req_t;

  typedef struct {
    logic signed [VALUE_W-1:0] curve_value;
    status_t                   status;
  } hermite_res_t;

  logic clk;
  logic rst = 1'b1;

  logic                      req_valid     = 1'b0;
  logic                      req_ready;
  logic        [VALUE_W-1:0] time_pos      = '0;
  logic        [VALUE_W-1:0] seg_length    = '0;
  logic signed [VALUE_W-1:0] start_value   = '0;
  logic signed [VALUE_W-1:0] start_tangent = '0;
  logic signed [VALUE_W-1:0] end_value     = '0;
  logic signed [VALUE_W-1:0] end_tangent   = '0;
  logic                      res_valid;
  logic                      res_ready     = 1'b0;
  logic signed [VALUE_W-1:0] curve_value;
  logic        [1:0]         status;

  hermite_req_t pending_segments[$];
  hermite_res_t expected_curve[$];

  int  n_total      = 0;
  int  n_requests   = 0;
  int  n_results    = 0;
  int  n_errors     = 0;
  int  status_count[4];
  int  idle_cycles  = 0;
  bit  timed_out    = 1'b0;
  int  req_gap      = 0;
  int  res_stall    = 0;
  bit  req_steady   = 1'b0;
  bit  res_steady   = 1'b1;

  cubic_hermite_evaluator_top DUT (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .time_pos     (time_pos),
    .seg_length   (seg_length),
    .start_value  (start_value),
    .start_tangent(start_tangent),
    .end_value    (end_value),
    .end_tangent  (end_tangent),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .curve_value  (curve_value),
    .status       (status)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // floor(x * u / 2^PHASE_BITS); arithmetic shift of the signed product floors
  function automatic logic signed [63:0] scale_by_phase(logic signed [63:0] x,
                                                        logic [63:0] phase);
    return (x * $signed(phase)) >>> PHASE_BITS;
  endfunction

  function automatic hermite_res_t hermite_eval(hermite_req_t q);
    logic        [63:0] phase;
    logic signed [63:0] p0, d0, p1, d1, acc;
    hermite_res_t res;
    res.status = ST_OK;
    if (q.seg_length == '0) begin
      res.curve_value = q.start_value;
      res.status      = ST_ZERO_LEN;
      return res;
    end
    if (q.time_pos > q.seg_length) begin
      phase      = 64'd1 << PHASE_BITS;
      res.status = ST_CLAMPED;
    end else begin
      phase = ({32'd0, q.time_pos} << PHASE_BITS) / {32'd0, q.seg_length};
    end
    p0 = q.start_value;
    d0 = q.start_tangent;
    p1 = q.end_value;
    d1 = q.end_tangent;
    acc = 2 * p0 - 2 * p1 + d0 + d1;
    acc = -3 * p0 + 3 * p1 - 2 * d0 - d1 + scale_by_phase(acc, phase);
    acc = d0 + scale_by_phase(acc, phase);
    acc = p0 + scale_by_phase(acc, phase);
    if (acc > VALUE_MAX) begin
      acc        = VALUE_MAX;
      res.status = ST_SATURATED;
    end else if (acc < VALUE_MIN) begin
      acc        = VALUE_MIN;
      res.status = ST_SATURATED;
    end
    res.curve_value = acc[VALUE_W-1:0];
    return res;
  endfunction

  function automatic int draw_wait(bit steady);
    return steady ? 0 : $urandom_range(0, 8);
  endfunction

  function automatic logic signed [VALUE_W-1:0] rand_value();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) return $signed($urandom_range(0, 32'h003F_FFFF)) - 32'sh0020_0000;
    if (pick < 65) return $signed($urandom_range(0, 32'h1FFF_FFFF)) - 32'sh1000_0000;
    if (pick < 90) return $signed($urandom());
    case ($urandom_range(0, 3))
      0:       return VALUE_MAX;
      1:       return VALUE_MIN;
      2:       return '0;
      default: return -1;
    endcase
  endfunction

  task automatic add_segment(logic [31:0] t, logic [31:0] len, logic signed [31:0] p0,
                             logic signed [31:0] d0, logic signed [31:0] p1,
                             logic signed [31:0] d1);
    hermite_req_t q;
    q.time_pos      = t;
    q.seg_length    = len;
    q.start_value   = p0;
    q.start_tangent = d0;
    q.end_value     = p1;
    q.end_tangent   = d1;
    pending_segments.push_back(q);
  endtask

  task automatic report_mismatch(string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    n_errors++;
  endtask

  always @(posedge clk) begin : request_driver
    hermite_req_t nxt;
    if (rst) begin
      req_valid <= 1'b0;
      req_gap   <= 0;
    end else if (!req_valid || req_ready) begin
      if (req_gap > 0) begin
        req_valid <= 1'b0;
        req_gap   <= req_gap - 1;
      end else if (pending_segments.size() > 0) begin
        nxt = pending_segments.pop_front();
        time_pos      <= nxt.time_pos;
        seg_length    <= nxt.seg_length;
        start_value   <= nxt.start_value;
        start_tangent <= nxt.start_tangent;
        end_value     <= nxt.end_value;
        end_tangent   <= nxt.end_tangent;
        req_valid     <= 1'b1;
        req_gap       <= draw_wait(req_steady);
        if ($urandom_range(0, 63) == 0) req_steady <= !req_steady;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : result_sink
    int stall;
    if (rst) begin
      res_ready <= 1'b0;
      res_stall <= 0;
    end else if (res_stall > 0) begin
      res_ready <= 1'b0;
      res_stall <= res_stall - 1;
    end else if (res_valid && res_ready) begin
      stall = draw_wait(res_steady);
      if ($urandom_range(0, 63) == 0) res_steady <= !res_steady;
      res_ready <= (stall == 0);
      res_stall <= (stall == 0) ? 0 : stall - 1;
    end else begin
      res_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : monitor
    hermite_req_t seen;
    hermite_res_t want;
    bit           moved;
    moved = 1'b0;
    if (!rst) begin
      if (req_valid && req_ready) begin
        seen.time_pos      = time_pos;
        seen.seg_length    = seg_length;
        seen.start_value   = start_value;
        seen.start_tangent = start_tangent;
        seen.end_value     = end_value;
        seen.end_tangent   = end_tangent;
        want = hermite_eval(seen);
        expected_curve.push_back(want);
        status_count[want.status]++;
        n_requests++;
        moved = 1'b1;
      end
      if (res_valid && res_ready) begin
        n_results++;
        moved = 1'b1;
        if (expected_curve.size() == 0) begin
          report_mismatch($sformatf("result value %h status %0d with no request outstanding",
                                    curve_value, status));
        end else begin
          want = expected_curve.pop_front();
          if (curve_value !== want.curve_value)
            report_mismatch($sformatf("result %0d curve_value %h, want %h",
                                      n_results, curve_value, want.curve_value));
          if (status !== want.status)
            report_mismatch($sformatf("result %0d status %0d, want %s",
                                      n_results, status, want.status.name()));
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) timed_out <= 1'b1;
    end
  end

  initial begin : main
    logic [31:0] len, t;
    int unsigned pick;

    // Directed: phase endpoints, zero length, clamping, saturation both ways,
    // floor rounding of negative products and field extremes.
    add_segment(0, 1000, 32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, -32'sh0001_0000);
    add_segment(1000, 1000, 32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, -32'sh0001_0000);
    add_segment(500, 1000, 32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, -32'sh0001_0000);
    add_segment(0, 0, 32'sh1234_5678, VALUE_MAX, VALUE_MIN, -1);
    add_segment(32'hFFFF_FFFF, 0, VALUE_MIN, VALUE_MIN, VALUE_MAX, VALUE_MAX);
    add_segment(0, 0, VALUE_MAX, 0, 0, 0);
    add_segment(1001, 1000, 32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, -32'sh0001_0000);
    add_segment(32'hFFFF_FFFF, 1, VALUE_MAX, VALUE_MIN, VALUE_MIN, VALUE_MAX);
    add_segment(32'hFFFF_FFFF, 32'hFFFF_FFFF, -32'sh0000_4000, 32'sh0100_0000, 32'sh7FFF_0000,
                VALUE_MIN);
    add_segment(32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'sh0000_0001, VALUE_MAX, -32'sh0000_0001,
                VALUE_MAX);
    add_segment(1, 32'hFFFF_FFFF, VALUE_MIN, VALUE_MAX, VALUE_MAX, VALUE_MIN);
    add_segment(0, 32'hFFFF_FFFF, VALUE_MIN, -1, VALUE_MAX, 0);
    add_segment(32'h8000_0000, 32'hFFFF_FFFF, -1, -1, -1, -1);
    add_segment(1, 2, VALUE_MAX, VALUE_MAX, VALUE_MAX, VALUE_MIN);
    add_segment(1, 2, VALUE_MIN, VALUE_MIN, VALUE_MIN, VALUE_MAX);
    add_segment(1, 3, -1, -3, -7, 5);
    add_segment(2, 3, -32'sh0000_0005, 32'sh0000_0003, -32'sh0000_0002, -32'sh0000_000B);
    add_segment(1, 3, VALUE_MAX, VALUE_MIN, VALUE_MIN, VALUE_MIN);
    add_segment(2, 3, VALUE_MIN, VALUE_MAX, VALUE_MAX, VALUE_MAX);
    add_segment(6, 7, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh3333_3333, 32'shCCCC_CCCC);
    add_segment(32'hFFFF_FFFF, 32'h7FFF_FFFF, VALUE_MAX, VALUE_MAX, VALUE_MIN, VALUE_MIN);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 4)       len = 0;
      else if (pick < 30) len = $urandom_range(1, 64);
      else if (pick < 60) len = $urandom_range(1, 65535);
      else                len = $urandom();
      pick = $urandom_range(0, 99);
      if (pick < 8)
        t = len;
      else if (pick < 18)
        t = (len == 32'hFFFF_FFFF) ? len : $urandom_range(len + 32'd1, 32'hFFFF_FFFF);
      else if (pick < 24)
        t = $urandom();
      else
        t = $urandom_range(0, len);
      add_segment(t, len, rand_value(), rand_value(), rand_value(), rand_value());
    end
    n_total = pending_segments.size();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (!timed_out && !(n_requests == n_total && expected_curve.size() == 0))
      @(posedge clk);
    if (!timed_out) begin
      // let a stray extra result show up before closing
      for (int i = 0; i < 2 * PIPE_LATENCY && !timed_out; i++) @(posedge clk);
      if (expected_curve.size() > 0)
        report_mismatch($sformatf("%0d results never arrived", expected_curve.size()));
    end

    if (timed_out) begin
      $display("Timeout: %0d of %0d requests taken, %0d results seen",
               n_requests, n_total, n_results);
      $display("Verification failed");
    end else begin
      $display("Evaluated %0d segments: %0d in range, %0d zero length, %0d clamped, %0d saturated",
               n_requests, status_count[ST_OK], status_count[ST_ZERO_LEN],
               status_count[ST_CLAMPED], status_count[ST_SATURATED]);
      $display("Checked %0d results with random stalls on both channels, %0d mismatches",
               n_results, n_errors);
      if (n_errors == 0) begin
        $display("Verification passed");
      end else begin
        $display("Verification failed");
      end
    end
    $finish;
  end

endmodule
